/* hw/rtl/t3_moving_average_filter_defines.svh */
// Assertion macros used by the checker file of the T3 filter.
`ifndef T3_MOVING_AVERAGE_FILTER_DEFINES_SVH
`define T3_MOVING_AVERAGE_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define T3MA_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication.
`define T3MA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// Delayed implication.
`define T3MA_ASSERT_DLY2(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("%m: two-cycle check failed");

`endif

/* hw/rtl/t3ma_pkg.sv */
// Types and constants of the T3 moving average filter.
package t3ma_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int CELL_W     = 48;
  localparam int DIFF_W     = CELL_W + 1;
  localparam int ALPHA_W    = 17;
  localparam int VF_W       = 16;
  localparam int COEF_W     = ALPHA_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ALPHA_W;

  localparam int NUM_STAGES = 3;
  localparam int STAGE_W    = 2;

  // Split multiply: low part unsigned, high part signed.
  localparam int LO_W    = 24;
  localparam int HI_W    = DIFF_W - LO_W;
  localparam int MUL_A_W = HI_W;
  localparam int MUL_B_W = COEF_W + 1;
  localparam int MUL_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 68;

  localparam int ALPHA_SHIFT = 16;
  localparam int VF_SHIFT    = 12;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd21845;
  localparam logic [VF_W-1:0]    VF_RESET    = 16'd2867;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VF    = 2'd1;

  localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(NUM_STAGES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_MLO,
    ST_MHI,
    ST_ACC,
    ST_DONE
  } t3ma_state_t;

  typedef enum logic [1:0] {
    OP_FAST,
    OP_SLOW,
    OP_GD
  } t3ma_op_t;

  typedef struct packed {
    t3ma_state_t          state;
    t3ma_op_t             op;
    logic [STAGE_W-1:0]   stage;
    logic                 accept;
    logic                 prime;
    logic                 out_load;
  } t3ma_ctl_t;

endpackage

/* hw/rtl/t3ma_mul_unit.sv */
// Shared multiply-round-add unit: base + round(diff * coef / 2^sh), saturated.
module t3ma_mul_unit (
  input  logic                                 clk,
  input  t3ma_pkg::t3ma_ctl_t                  ctl,
  input  logic signed [t3ma_pkg::CELL_W-1:0]   opa,
  input  logic signed [t3ma_pkg::CELL_W-1:0]   opb,
  input  logic signed [t3ma_pkg::CELL_W-1:0]   base,
  input  logic        [t3ma_pkg::COEF_W-1:0]   coef,
  input  logic                                 vf_sel,
  output logic signed [t3ma_pkg::CELL_W-1:0]   res
);

  logic signed [t3ma_pkg::DIFF_W-1:0]  diff_r;
  logic signed [t3ma_pkg::CELL_W-1:0]  base_r;
  logic        [t3ma_pkg::COEF_W-1:0]  coef_r;
  logic                                vf_sel_r;
  logic signed [t3ma_pkg::MUL_W-1:0]   p_r;
  logic signed [t3ma_pkg::MUL_W-1:0]   q_r;
  logic signed [t3ma_pkg::ACC_W-1:0]   s_r;
  logic signed [t3ma_pkg::ACC_W-1:0]   s_nxt;

  logic signed [t3ma_pkg::MUL_A_W-1:0] mul_a;
  logic signed [t3ma_pkg::MUL_B_W-1:0] mul_b;
  logic signed [t3ma_pkg::MUL_W-1:0]   prod;

  logic signed [t3ma_pkg::ACC_W-1:0]   p_ext;
  logic signed [t3ma_pkg::ACC_W-1:0]   q_ext;
  logic signed [t3ma_pkg::ACC_W-1:0]   base_ext;
  logic signed [t3ma_pkg::ACC_W-1:0]   rnd;
  logic signed [t3ma_pkg::ACC_W-1:0]   sum;
  logic signed [t3ma_pkg::ACC_W-1:0]   shifted;
  logic        [t3ma_pkg::ACC_W-t3ma_pkg::CELL_W:0] upper;

  // one multiplier: low digit (zero-extended) then high digit (signed)
  always_comb begin
    if (ctl.state == t3ma_pkg::ST_MLO) begin
      mul_a = $signed({1'b0, diff_r[t3ma_pkg::LO_W-1:0]});
    end else begin
      mul_a = diff_r[t3ma_pkg::DIFF_W-1:t3ma_pkg::LO_W];
    end
    mul_b = $signed({1'b0, coef_r});
  end

  assign prod = mul_a * mul_b;

  // base folded in as base << sh so the final step is one add and a shift
  always_comb begin
    p_ext    = {{(t3ma_pkg::ACC_W - t3ma_pkg::MUL_W){p_r[t3ma_pkg::MUL_W-1]}}, p_r};
    base_ext = {{(t3ma_pkg::ACC_W - t3ma_pkg::CELL_W){base_r[t3ma_pkg::CELL_W-1]}}, base_r};
    if (vf_sel_r) begin
      rnd   = t3ma_pkg::ACC_W'(1) <<< (t3ma_pkg::VF_SHIFT - 1);
      s_nxt = p_ext + rnd + (base_ext <<< t3ma_pkg::VF_SHIFT);
    end else begin
      rnd   = t3ma_pkg::ACC_W'(1) <<< (t3ma_pkg::ALPHA_SHIFT - 1);
      s_nxt = p_ext + rnd + (base_ext <<< t3ma_pkg::ALPHA_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.state)
      t3ma_pkg::ST_SUB: begin
        diff_r   <= {opa[t3ma_pkg::CELL_W-1], opa} - {opb[t3ma_pkg::CELL_W-1], opb};
        base_r   <= base;
        coef_r   <= coef;
        vf_sel_r <= vf_sel;
      end
      t3ma_pkg::ST_MLO: begin
        p_r <= prod;
      end
      t3ma_pkg::ST_MHI: begin
        q_r <= prod;
        s_r <= s_nxt;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    q_ext = {{(t3ma_pkg::ACC_W - t3ma_pkg::MUL_W){q_r[t3ma_pkg::MUL_W-1]}}, q_r};
    sum   = (q_ext <<< t3ma_pkg::LO_W) + s_r;
    if (vf_sel_r) begin
      shifted = sum >>> t3ma_pkg::VF_SHIFT;
    end else begin
      shifted = sum >>> t3ma_pkg::ALPHA_SHIFT;
    end
    upper = shifted[t3ma_pkg::ACC_W-1:t3ma_pkg::CELL_W-1];
    if ((&upper) || (~|upper)) begin
      res = shifted[t3ma_pkg::CELL_W-1:0];
    end else if (upper[t3ma_pkg::ACC_W-t3ma_pkg::CELL_W]) begin
      res = {1'b1, {(t3ma_pkg::CELL_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(t3ma_pkg::CELL_W-1){1'b1}}};
    end
  end

endmodule

/* hw/rtl/t3ma_ctrl.sv */
// Sequencer of the T3 filter: steps stages, operations and unit phases.
module t3ma_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_start_req,
  input  logic                 out_valid,
  input  logic                 out_stall,
  output logic                 in_stall,
  output t3ma_pkg::t3ma_ctl_t  ctl
);

  t3ma_pkg::t3ma_state_t          state_r, state_nxt;
  t3ma_pkg::t3ma_op_t             op_r, op_nxt;
  logic [t3ma_pkg::STAGE_W-1:0]   stage_r, stage_nxt;
  logic                           primed_r, primed_nxt;
  logic                           accept;
  logic                           prime;
  logic                           out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= t3ma_pkg::ST_IDLE;
      op_r     <= t3ma_pkg::OP_FAST;
      stage_r  <= '0;
      primed_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      op_r     <= op_nxt;
      stage_r  <= stage_nxt;
      primed_r <= primed_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    stage_nxt  = stage_r;
    primed_nxt = primed_r;
    accept     = 1'b0;
    prime      = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      t3ma_pkg::ST_IDLE: begin
        if (in_valid) begin
          accept = 1'b1;
          if (in_start_req || !primed_r) begin
            prime      = 1'b1;
            primed_nxt = 1'b1;
            state_nxt  = t3ma_pkg::ST_DONE;
          end else begin
            op_nxt    = t3ma_pkg::OP_FAST;
            stage_nxt = '0;
            state_nxt = t3ma_pkg::ST_SUB;
          end
        end
      end
      t3ma_pkg::ST_SUB: state_nxt = t3ma_pkg::ST_MLO;
      t3ma_pkg::ST_MLO: state_nxt = t3ma_pkg::ST_MHI;
      t3ma_pkg::ST_MHI: state_nxt = t3ma_pkg::ST_ACC;
      t3ma_pkg::ST_ACC: begin
        state_nxt = t3ma_pkg::ST_SUB;
        case (op_r)
          t3ma_pkg::OP_FAST: op_nxt = t3ma_pkg::OP_SLOW;
          t3ma_pkg::OP_SLOW: op_nxt = t3ma_pkg::OP_GD;
          default: begin
            op_nxt = t3ma_pkg::OP_FAST;
            if (stage_r == t3ma_pkg::LAST_STAGE) begin
              state_nxt = t3ma_pkg::ST_DONE;
            end else begin
              stage_nxt = stage_r + 1'b1;
            end
          end
        endcase
      end
      t3ma_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = t3ma_pkg::ST_IDLE;
        end
      end
      default: state_nxt = t3ma_pkg::ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != t3ma_pkg::ST_IDLE);

  always_comb begin
    ctl.state    = state_r;
    ctl.op       = op_r;
    ctl.stage    = stage_r;
    ctl.accept   = accept;
    ctl.prime    = prime;
    ctl.out_load = out_load;
  end

endmodule

/* hw/rtl/t3_moving_average_filter.sv */
// Top level of the T3 moving average filter.
//
// Input channel: in_valid / in_stall carry one signed Q16.16 sample and a
// start_req flag per beat. Output channel: out_valid / out_stall carry one
// saturated T3 value per input beat, in order.
// Config: cfg_we writes cfg_wdata to register cfg_index (0 = alpha, Q1.16,
// 1 = volume factor, Q4.12); unknown indexes are dropped. Write only when idle.
//
// A priming beat (first after reset, or start_req set) is echoed through
// the done state into the output register. Any other beat runs nine
// multiply-round-add operations (fast EMA, slow EMA, GD per stage, three
// stages) on one shared 25x18 multiplier, each as subtract, low digit, high
// digit and accumulate steps, then passes through the done state into the
// output register. The next beat is taken only once the block is back in
// idle.
// in_stall is high while an item is in flight. The finished result sits in
// the output register; a stalled receiver holds the block in its final step
// only if a second result is ready before the first is taken.
// Reset (rst_n low, synchronous) clears control state and reloads the
// default alpha and volume factor; the EMA cells are refilled by priming.
module t3_moving_average_filter (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [t3ma_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                                   in_start_req,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [t3ma_pkg::SAMPLE_W-1:0]   out_t3_value,
  input  logic                                   cfg_we,
  input  logic        [t3ma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [t3ma_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  t3ma_pkg::t3ma_ctl_t ctl;

  logic [t3ma_pkg::ALPHA_W-1:0] alpha_r;
  logic [t3ma_pkg::VF_W-1:0]    vf_r;
  logic [t3ma_pkg::ALPHA_W-1:0] alpha_eff;

  // EMA cells, one pair per GD stage
  logic signed [t3ma_pkg::CELL_W-1:0] fast_r [t3ma_pkg::NUM_STAGES];
  logic signed [t3ma_pkg::CELL_W-1:0] slow_r [t3ma_pkg::NUM_STAGES];
  // running stage input / final GD value
  logic signed [t3ma_pkg::CELL_W-1:0] x_r;
  logic signed [t3ma_pkg::CELL_W-1:0] sample_ext;

  logic signed [t3ma_pkg::CELL_W-1:0] opa, opb, base, res;
  logic        [t3ma_pkg::COEF_W-1:0] coef;
  logic                               vf_sel;

  logic                                 out_valid_r, out_valid_nxt;
  logic signed [t3ma_pkg::SAMPLE_W-1:0] out_t3_value_r;
  logic signed [t3ma_pkg::SAMPLE_W-1:0] x_sat;
  logic [t3ma_pkg::CELL_W-t3ma_pkg::SAMPLE_W:0] x_upper;

  t3ma_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_start_req (in_start_req),
    .out_valid    (out_valid_r),
    .out_stall    (out_stall),
    .in_stall     (in_stall),
    .ctl          (ctl)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= t3ma_pkg::ALPHA_RESET;
      vf_r    <= t3ma_pkg::VF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        t3ma_pkg::CFG_ALPHA: alpha_r <= cfg_wdata;
        t3ma_pkg::CFG_VF:    vf_r    <= cfg_wdata[t3ma_pkg::VF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // alpha above 1.0 acts as 1.0
  assign alpha_eff = (alpha_r > t3ma_pkg::ALPHA_ONE) ? t3ma_pkg::ALPHA_ONE : alpha_r;

  assign sample_ext = {{(t3ma_pkg::CELL_W - t3ma_pkg::SAMPLE_W){in_sample[t3ma_pkg::SAMPLE_W-1]}},
                       in_sample};

  // operand select for the shared unit
  //   fast: f + R((x - f) * a)   slow: w + R((f - w) * a)   gd: f + R((f - w) * v)
  always_comb begin
    case (ctl.op)
      t3ma_pkg::OP_FAST: begin
        opa    = x_r;
        opb    = fast_r[ctl.stage];
        base   = fast_r[ctl.stage];
        coef   = alpha_eff;
        vf_sel = 1'b0;
      end
      t3ma_pkg::OP_SLOW: begin
        opa    = fast_r[ctl.stage];
        opb    = slow_r[ctl.stage];
        base   = slow_r[ctl.stage];
        coef   = alpha_eff;
        vf_sel = 1'b0;
      end
      default: begin
        opa    = fast_r[ctl.stage];
        opb    = slow_r[ctl.stage];
        base   = fast_r[ctl.stage];
        coef   = {1'b0, vf_r};
        vf_sel = 1'b1;
      end
    endcase
  end

  t3ma_mul_unit u_mul (
    .clk    (clk),
    .ctl    (ctl),
    .opa    (opa),
    .opb    (opb),
    .base   (base),
    .coef   (coef),
    .vf_sel (vf_sel),
    .res    (res)
  );

  // cell and stage-input write-back
  always_ff @(posedge clk) begin
    if (ctl.prime) begin
      for (int k = 0; k < t3ma_pkg::NUM_STAGES; k++) begin
        fast_r[k] <= sample_ext;
        slow_r[k] <= sample_ext;
      end
    end else if (ctl.state == t3ma_pkg::ST_ACC) begin
      case (ctl.op)
        t3ma_pkg::OP_FAST: fast_r[ctl.stage] <= res;
        t3ma_pkg::OP_SLOW: slow_r[ctl.stage] <= res;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      x_r <= sample_ext;
    end else if (ctl.state == t3ma_pkg::ST_ACC && ctl.op == t3ma_pkg::OP_GD) begin
      x_r <= res;
    end
  end

  // saturate the last GD to the sample format
  always_comb begin
    x_upper = x_r[t3ma_pkg::CELL_W-1:t3ma_pkg::SAMPLE_W-1];
    if ((&x_upper) || (~|x_upper)) begin
      x_sat = x_r[t3ma_pkg::SAMPLE_W-1:0];
    end else if (x_upper[t3ma_pkg::CELL_W-t3ma_pkg::SAMPLE_W]) begin
      x_sat = {1'b1, {(t3ma_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      x_sat = {1'b0, {(t3ma_pkg::SAMPLE_W-1){1'b1}}};
    end
  end

  // output register
  always_comb begin
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_t3_value_r <= x_sat;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_t3_value = out_t3_value_r;

endmodule

/* hw/rtl/t3ma_checker.sv */
// Port-level checker for the T3 filter, bound to the top level.
`include "t3_moving_average_filter_defines.svh"

module t3ma_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [t3ma_pkg::SAMPLE_W-1:0]     in_sample,
  input logic                              in_start_req,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [t3ma_pkg::SAMPLE_W-1:0]     out_t3_value
);

  // a result waiting on the receiver stays
  `T3MA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // and keeps its value
  `T3MA_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_t3_value))

  // one beat at a time: busy right after a beat is taken
  `T3MA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a restart beat is echoed through the final step when the output is free
  `T3MA_ASSERT_DLY2(a_restart_echo,
    in_valid && !in_stall && in_start_req && !out_valid,
    out_valid && (out_t3_value == $past(in_sample, 2)))

endmodule

bind t3_moving_average_filter t3ma_checker u_t3ma_checker (.*);

/* dv/t3_moving_average_filter_test.sv */
// Self-checking testbench of the T3 moving average filter: directed, random and stall tests.
module t3_moving_average_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Predictor works on wide signed values so no product overflows.
  typedef logic signed [95:0] wide_t;

  localparam wide_t CELL_HI = (wide_t'(1) <<< (t3ma_pkg::CELL_W - 1)) - 1;
  localparam wide_t CELL_LO = -(wide_t'(1) <<< (t3ma_pkg::CELL_W - 1));
  localparam wide_t OUT_HI  = (wide_t'(1) <<< (t3ma_pkg::SAMPLE_W - 1)) - 1;
  localparam wide_t OUT_LO  = -(wide_t'(1) <<< (t3ma_pkg::SAMPLE_W - 1));

  localparam logic signed [t3ma_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [t3ma_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

  // Register indexes with no register behind them; writes there are dropped.
  localparam logic [t3ma_pkg::CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [t3ma_pkg::CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;

  localparam logic [t3ma_pkg::ALPHA_W-1:0] ALPHA_TOP = 17'h1_FFFF;
  localparam logic [t3ma_pkg::VF_W-1:0]    VF_TOP    = 16'hFFFF;

  // ---------------------------------------------------------------------------
  // Clock, reset and block I/O. Every input holds a known value from time zero.
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic signed [t3ma_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic                                 in_start_req = 1'b0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic signed [t3ma_pkg::SAMPLE_W-1:0] out_t3_value;
  logic                                 cfg_we = 1'b0;
  logic [t3ma_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [t3ma_pkg::CFG_DATA_W-1:0]      cfg_wdata = '0;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  t3_moving_average_filter DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .in_start_req (in_start_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_t3_value (out_t3_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the filter: registers, priming flag and the six EMA cells.
  // ---------------------------------------------------------------------------
  logic [t3ma_pkg::ALPHA_W-1:0] alpha_shadow;
  logic [t3ma_pkg::VF_W-1:0]    vf_shadow;
  bit                           series_primed;
  wide_t                        fast_cell [t3ma_pkg::NUM_STAGES];
  wide_t                        slow_cell [t3ma_pkg::NUM_STAGES];

  logic signed [t3ma_pkg::SAMPLE_W-1:0] expected_t3_q [$];

  int errors = 0;
  int beats_in = 0;
  int values_checked = 0;
  int reg_writes = 0;

  // Idle controls: sender gaps, receiver stall bursts, one long hold-off.
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int rx_hold_req = 0;

  // floor((d * m + half) / 2^sh), exact on the full product.
  function automatic wide_t scale_round(wide_t d, logic [16:0] m, int sh);
    wide_t p;
    p = d * $signed({79'b0, m});
    p = p + (wide_t'(1) <<< (sh - 1));
    return p >>> sh;
  endfunction

  function automatic wide_t clamp_to(wide_t v, wide_t lo, wide_t hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advances the shadow by one accepted beat and returns the T3 value it yields.
  function automatic logic signed [t3ma_pkg::SAMPLE_W-1:0] t3_predict(
      logic signed [t3ma_pkg::SAMPLE_W-1:0] s, logic restart);
    wide_t       x;
    wide_t       f;
    wide_t       w;
    logic [16:0] a;
    int          k;
    // alpha above one behaves as exactly one
    a = (alpha_shadow > t3ma_pkg::ALPHA_ONE) ? t3ma_pkg::ALPHA_ONE : alpha_shadow;
    if (restart || !series_primed) begin
      // priming: every cell takes the sample, which is echoed unchanged
      for (k = 0; k < t3ma_pkg::NUM_STAGES; k++) begin
        fast_cell[k] = wide_t'(s);
        slow_cell[k] = wide_t'(s);
      end
      series_primed = 1'b1;
      return s;
    end
    x = wide_t'(s);
    for (k = 0; k < t3ma_pkg::NUM_STAGES; k++) begin
      f = fast_cell[k] + scale_round(x - fast_cell[k], a, t3ma_pkg::ALPHA_SHIFT);
      w = slow_cell[k] + scale_round(f - slow_cell[k], a, t3ma_pkg::ALPHA_SHIFT);
      fast_cell[k] = f;
      slow_cell[k] = w;
      // generalized DEMA, kept inside the 48-bit cell range
      x = clamp_to(f + scale_round(f - w, {1'b0, vf_shadow}, t3ma_pkg::VF_SHIFT),
                   CELL_LO, CELL_HI);
    end
    return t3ma_pkg::SAMPLE_W'(clamp_to(x, OUT_LO, OUT_HI));
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, or one long hold-off counted here.
  // ---------------------------------------------------------------------------
  initial begin : rx_stall_gen
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (rx_hold_req > 0) begin
        stall_left = rx_hold_req - 1;
        rx_hold_req = 0;
        out_stall <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every output beat against the oldest expected value.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic signed [t3ma_pkg::SAMPLE_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_t3_q.size() == 0) begin
        $display("%0t: unexpected output beat: expected none, actual %0d", $time, out_t3_value);
        errors++;
      end else begin
        want = expected_t3_q.pop_front();
        values_checked++;
        if (out_t3_value !== want) begin
          $display("%0t: t3_value mismatch: expected %0d, actual %0d",
                   $time, want, out_t3_value);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared tasks. All of them start and end in the time step of a rising edge.
  // ---------------------------------------------------------------------------

  // Offers one beat and waits until it is taken. Unless a random gap lowers in_valid,
  // it stays high on return, so beats can go out back to back; park_sender lowers it.
  task automatic send_sample(logic signed [t3ma_pkg::SAMPLE_W-1:0] s, logic restart);
    in_valid     <= 1'b1;
    in_sample    <= s;
    in_start_req <= restart;
    do @(posedge clk); while (in_stall);
    expected_t3_q.push_back(t3_predict(s, restart));
    beats_in++;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every expected value has come out.
  task automatic park_sender();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (expected_t3_q.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (expected_t3_q.size() != 0) begin
      $display("%0t: drain stalled: expected %0d more values, actual 0",
               $time, expected_t3_q.size());
      errors++;
      expected_t3_q.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  // Register write; only issued with the block idle.
  task automatic write_reg(logic [t3ma_pkg::CFG_IDX_W-1:0] idx,
                           logic [t3ma_pkg::CFG_DATA_W-1:0] data);
    park_sender();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    // the write lands at this edge
    if (idx == t3ma_pkg::CFG_ALPHA) alpha_shadow = data;
    else if (idx == t3ma_pkg::CFG_VF) vf_shadow = data[t3ma_pkg::VF_W-1:0];
    reg_writes++;
    cfg_we <= 1'b0;
  endtask

  // Random sample of a running series: mostly small moves, some jumps,
  // extremes, full-range noise and restarts.
  task automatic send_series_beat(inout logic signed [t3ma_pkg::SAMPLE_W-1:0] level);
    logic signed [t3ma_pkg::SAMPLE_W-1:0] step;
    logic                                 restart;
    restart = 1'b0;
    case ($urandom_range(0, 15))
      0:       level = $urandom;
      1:       level = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      2: begin
        restart = ($urandom_range(0, 2) == 0);
        level   = $urandom;
      end
      default: begin
        step  = $signed($urandom) >>> $urandom_range(6, 28);
        level = level + step;
      end
    endcase
    send_sample(level, restart);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default registers: priming echo, full-scale steps, restart while primed.
  task automatic test_default_series();
    send_sample(SAMPLE_MAX, 1'b0);   // first beat after reset primes
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample('0, 1'b1);           // restart while primed
    send_sample(32'sd1, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sh0001_0000, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
  endtask

  // Register corners: alpha one, alpha above one, alpha zero, v at both ends,
  // and writes to the unused indexes.
  task automatic test_register_corners();
    write_reg(t3ma_pkg::CFG_ALPHA,
              {1'b0, t3ma_pkg::ALPHA_ONE[t3ma_pkg::ALPHA_W-2:0]} | t3ma_pkg::ALPHA_ONE);
    write_reg(t3ma_pkg::CFG_VF, {1'b0, VF_TOP});
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);   // with alpha one the output follows the sample
    send_sample(SAMPLE_MIN, 1'b0);
    write_reg(t3ma_pkg::CFG_ALPHA, ALPHA_TOP); // above one acts as one
    write_reg(t3ma_pkg::CFG_VF, '0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(32'sh1234_5678, 1'b0);
    write_reg(t3ma_pkg::CFG_ALPHA, {1'b0, 16'h8000});
    write_reg(t3ma_pkg::CFG_VF, {1'b1, VF_TOP}); // bit above the register is dropped
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    write_reg(t3ma_pkg::CFG_ALPHA, '0);        // cells freeze, output repeats
    send_sample(32'sd5, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    write_reg(CFG_UNUSED_2, ALPHA_TOP);
    write_reg(CFG_UNUSED_3, '0);
    send_sample(SAMPLE_MAX, 1'b0);
    write_reg(t3ma_pkg::CFG_ALPHA, t3ma_pkg::ALPHA_RESET);
    write_reg(t3ma_pkg::CFG_VF, {1'b0, t3ma_pkg::VF_RESET});
    send_sample('0, 1'b0);
  endtask

  // Random series under a series of random register settings.
  task automatic test_random_series();
    logic signed [t3ma_pkg::SAMPLE_W-1:0] level;
    logic [t3ma_pkg::CFG_DATA_W-1:0]      a;
    logic [t3ma_pkg::CFG_DATA_W-1:0]      v;
    int                                   p;
    int                                   n;
    for (p = 0; p < 8; p++) begin
      case ($urandom_range(0, 7))
        0:       a = t3ma_pkg::CFG_DATA_W'($urandom_range(0, 17'h1_FFFF));
        1:       a = t3ma_pkg::ALPHA_ONE;
        2:       a = t3ma_pkg::CFG_DATA_W'($urandom_range(1, 255));
        default: a = t3ma_pkg::CFG_DATA_W'($urandom_range(1000, 40000));
      endcase
      case ($urandom_range(0, 5))
        0:       v = '0;
        1:       v = t3ma_pkg::CFG_DATA_W'($urandom_range(0, 17'h1_FFFF));
        default: v = t3ma_pkg::CFG_DATA_W'($urandom_range(0, 8191));
      endcase
      write_reg(t3ma_pkg::CFG_ALPHA, a);
      write_reg(t3ma_pkg::CFG_VF, v);
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? CFG_UNUSED_2 : CFG_UNUSED_3,
                  t3ma_pkg::CFG_DATA_W'($urandom_range(0, 17'h1_FFFF)));
      level = $urandom;
      send_sample(level, 1'b1);
      for (n = 0; n < 70; n++) send_series_beat(level);
    end
  endtask

  // Long receiver hold-off while the sender keeps offering beats back to
  // back, so the output register fills and the input side backs up.
  task automatic test_output_holdoff();
    logic signed [t3ma_pkg::SAMPLE_W-1:0] level;
    int                                   n;
    park_sender();
    tx_idle_en  = 1'b0;
    rx_hold_req = 300;
    level = $urandom;
    send_sample(level, 1'b1);
    for (n = 0; n < 12; n++) send_series_beat(level);
    tx_idle_en = 1'b1;
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_full_rate_tail();
    logic signed [t3ma_pkg::SAMPLE_W-1:0] level;
    int                                   n;
    park_sender();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    write_reg(t3ma_pkg::CFG_ALPHA, t3ma_pkg::CFG_DATA_W'($urandom_range(2000, 30000)));
    write_reg(t3ma_pkg::CFG_VF, {1'b0, t3ma_pkg::VF_RESET});
    level = $urandom;
    send_sample(level, 1'b1);
    for (n = 0; n < 40; n++) send_series_beat(level);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    alpha_shadow  = t3ma_pkg::ALPHA_RESET;
    vf_shadow     = t3ma_pkg::VF_RESET;
    series_primed = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_series();
    test_register_corners();
    test_random_series();
    test_output_holdoff();
    test_full_rate_tail();

    park_sender();
    repeat (48) @(posedge clk);
    if (expected_t3_q.size() != 0) begin
      $display("%0t: leftover values: expected 0, actual %0d", $time, expected_t3_q.size());
      errors++;
    end

    $display("Ran %0d sample beats with %0d register writes; %0d T3 values checked.",
             beats_in, reg_writes, values_checked);
    $display("Covered priming, restarts, alpha 0 / 1 / above 1, v extremes, saturation, stalls.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
